[hw/rtl/vqdcm_pkg.sv]
`timescale 1ns / 1ps

package vqdcm_pkg;

	// Result kinds
	localparam logic [2:0] KIND_HDR    = 3'd0;
	localparam logic [2:0] KIND_PRESET = 3'd1;
	localparam logic [2:0] KIND_DESC   = 3'd2;
	localparam logic [2:0] KIND_POST   = 3'd3;
	localparam logic [2:0] KIND_NODESC = 3'd4;
	localparam logic [2:0] KIND_DONE   = 3'd5;
	localparam logic [2:0] KIND_ERR    = 3'd6;

	// Error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_STATUS = 2'd1;
	localparam logic [1:0] ERR_RANGE  = 2'd2;
	localparam logic [1:0] ERR_DFREE  = 2'd3;

	// Config register indexes
	localparam logic [1:0] CFG_HDR_BASE = 2'd0;
	localparam logic [1:0] CFG_STS_BASE = 2'd1;
	localparam logic [1:0] CFG_BSL      = 2'd2;

	// Descriptor flags
	localparam logic [1:0] DF_NEXT  = 2'b01;
	localparam logic [1:0] DF_WRITE = 2'b10;

	localparam logic [12:0] HDR_LEN      = 13'd16;
	localparam logic [12:0] STS_LEN      = 13'd1;
	localparam logic [12:0] BLK_BASE_LEN = 13'd512;
	localparam logic [2:0]  MAX_STEP     = 3'd6;   // walk stops after seven descriptors

	typedef struct packed {
		logic        req_type;
		logic        is_write;
		logic [31:0] block_number;
		logic [63:0] data_addr;
		logic [15:0] head_id;
		logic [7:0]  device_status;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] target_addr;
		logic [7:0]  desc_index;
		logic [63:0] desc_addr;
		logic [12:0] desc_len;
		logic [1:0]  desc_flags;
		logic [7:0]  desc_next;
		logic        blk_type;
		logic [34:0] sector;
		logic [15:0] avail_idx;
		logic [1:0]  error_code;
		logic        last;
	} result_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [63:0] a;
		logic [63:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [63:0] sum;
		logic        carry;
	} alu_rsp_t;

endpackage

[hw/rtl/vqdcm_ram.sv]
`timescale 1ns / 1ps

module vqdcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/vqdcm_alu.sv]
`timescale 1ns / 1ps

module vqdcm_alu (
	input  vqdcm_pkg::alu_req_t req,
	output vqdcm_pkg::alu_rsp_t rsp
);

	logic [64:0] sum;

	// sub: carry set means a >= b
	always_comb begin
		unique case (req.op)
			vqdcm_pkg::ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
			vqdcm_pkg::ALU_SUB: sum = {1'b0, req.a} + {1'b0, ~req.b} + 65'd1;
			default:            sum = '0;
		endcase
		rsp.sum   = sum[63:0];
		rsp.carry = sum[64];
	end

endmodule

[hw/rtl/virtqueue_descriptor_chain_manager.sv]
`timescale 1ns / 1ps
// Split-virtqueue descriptor manager for block requests (driver side).
// Command channel: an item (cmd) is taken on a clock edge with start high and
// busy low. busy drops in the cycle that strobes the item's last result.
// Result channel: result_valid pulses for one cycle per result item; the
// receiver cannot stall, so every result must be captured when strobed.
// Config: cfg_we/cfg_index/cfg_data write one register per edge; write only
// while busy is low. Index 0 header base, 1 status base, 2 log2(block/512).
// Submit: the free map is scanned one descriptor a cycle, lowest first,
// until three free ones are found. Then one shared 64-bit adder forms
// the header and status addresses, and six results follow one per cycle.
// With fewer than three free a single no-descriptor result ends the item.
// Completion: each descriptor freed takes a range/free check, then the
// registered chain RAM read, and a done result ends the walk; a nonzero
// device status adds an error result right after the accept, at no cost.
// Reset: all descriptors free, avail counter zero, config at defaults. The
// chain RAM needs no clearing: only allocated entries are ever read.
module virtqueue_descriptor_chain_manager #(
	parameter int QUEUE_SIZE = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  vqdcm_pkg::cmd_t     cmd,
	output logic                result_valid,
	output vqdcm_pkg::result_t  result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [63:0]         cfg_data
);

	localparam int IDX_W = $clog2(QUEUE_SIZE);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_SIZE - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_HADDR,
		S_SADDR,
		S_PRESET,
		S_D0,
		S_D1,
		S_D2,
		S_POST,
		S_CHK,
		S_NEXT
	} state_t;

	typedef logic [IDX_W+1:0] chain_t;   // {flags, next}

	// Config registers
	logic [63:0] hdr_base_q;
	logic [63:0] sts_base_q;
	logic [1:0]  bsl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_base_q <= '0;
			sts_base_q <= '0;
			bsl_q      <= 2'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vqdcm_pkg::CFG_HDR_BASE: hdr_base_q <= cfg_data;
				vqdcm_pkg::CFG_STS_BASE: sts_base_q <= cfg_data;
				vqdcm_pkg::CFG_BSL:      bsl_q      <= cfg_data[1:0];
				default:                 ;   // no such register
			endcase
		end
	end

	state_t             state_q, state_d;
	vqdcm_pkg::cmd_t    cmd_q;
	logic [QUEUE_SIZE-1:0] free_q;
	logic [IDX_W-1:0]   scan_q;
	logic [1:0]         found_q;
	logic [IDX_W-1:0]   got_q [3];
	logic [63:0]        haddr_q;
	logic [63:0]        saddr_q;
	logic [15:0]        avail_q;
	logic [15:0]        cur_q;
	logic [2:0]         step_q;
	logic               res_valid_q;
	vqdcm_pkg::result_t res_q;

	logic               rv_d;
	vqdcm_pkg::result_t res_d;

	vqdcm_pkg::alu_req_t alu_req;
	vqdcm_pkg::alu_rsp_t alu_rsp;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	chain_t           ram_wdata;
	chain_t           ram_rdata;

	logic [IDX_W-1:0]      cur_idx;
	logic                  scan_free;
	logic                  in_range;
	logic [1:0]            data_flags;
	logic                  walk_more;
	logic [QUEUE_SIZE-1:0] take_mask;

	assign cur_idx    = cur_q[IDX_W-1:0];
	assign scan_free  = free_q[scan_q];
	assign in_range   = !alu_rsp.carry;   // valid only in S_CHK
	assign data_flags = cmd_q.is_write ? vqdcm_pkg::DF_NEXT
	                                   : (vqdcm_pkg::DF_NEXT | vqdcm_pkg::DF_WRITE);
	assign walk_more  = ram_rdata[IDX_W] && (step_q != vqdcm_pkg::MAX_STEP);

	// the three descriptors taken by a submit
	always_comb begin
		take_mask           = '0;
		take_mask[got_q[0]] = 1'b1;
		take_mask[got_q[1]] = 1'b1;
		take_mask[got_q[2]] = 1'b1;
	end

	vqdcm_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	vqdcm_ram #(
		.WIDTH (IDX_W + 2),
		.DEPTH (QUEUE_SIZE)
	) u_chain_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cur_idx),
		.rdata (ram_rdata)
	);

	// Shared adder: address sums, avail increment, range compare
	always_comb begin
		alu_req.op = vqdcm_pkg::ALU_ADD;
		alu_req.a  = '0;
		alu_req.b  = '0;
		unique case (state_q)
			S_HADDR: begin
				alu_req.a = hdr_base_q;
				alu_req.b = 64'(got_q[0]) << 4;
			end
			S_SADDR: begin
				alu_req.a = sts_base_q;
				alu_req.b = 64'(got_q[0]);
			end
			S_POST: begin
				alu_req.a = 64'(avail_q);
				alu_req.b = 64'd1;
			end
			S_CHK: begin
				alu_req.op = vqdcm_pkg::ALU_SUB;
				alu_req.a  = 64'(cur_q);
				alu_req.b  = 64'(QUEUE_SIZE);
			end
			default: ;
		endcase
	end

	// Chain RAM writes during submit
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = got_q[0];
		ram_wdata = '0;
		unique case (state_q)
			S_PRESET: begin
				ram_we    = 1'b1;
				ram_waddr = got_q[0];
				ram_wdata = {vqdcm_pkg::DF_NEXT, got_q[1]};
			end
			S_D0: begin
				ram_we    = 1'b1;
				ram_waddr = got_q[1];
				ram_wdata = {data_flags, got_q[2]};
			end
			S_D1: begin
				ram_we    = 1'b1;
				ram_waddr = got_q[2];
				ram_wdata = {vqdcm_pkg::DF_WRITE, IDX_W'(0)};
			end
			default: ;
		endcase
	end

	// Next state and next result
	always_comb begin
		state_d = state_q;
		rv_d    = 1'b0;
		res_d   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (!cmd.req_type) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_CHK;
						if (cmd.device_status != 8'd0) begin
							rv_d             = 1'b1;
							res_d.kind       = vqdcm_pkg::KIND_ERR;
							res_d.error_code = vqdcm_pkg::ERR_STATUS;
						end
					end
				end
			end
			S_SCAN: begin
				if (scan_free && found_q == 2'd2) begin
					state_d = S_HADDR;
				end else if (scan_q == LAST_IDX) begin
					rv_d       = 1'b1;
					res_d.kind = vqdcm_pkg::KIND_NODESC;
					res_d.last = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_HADDR: begin
				state_d = S_SADDR;
			end
			S_SADDR: begin
				rv_d              = 1'b1;
				res_d.kind        = vqdcm_pkg::KIND_HDR;
				res_d.target_addr = haddr_q;
				res_d.desc_index  = 8'(got_q[0]);
				res_d.blk_type    = cmd_q.is_write;
				res_d.sector      = 35'(cmd_q.block_number) << bsl_q;
				state_d           = S_PRESET;
			end
			S_PRESET: begin
				rv_d              = 1'b1;
				res_d.kind        = vqdcm_pkg::KIND_PRESET;
				res_d.target_addr = saddr_q;
				res_d.desc_index  = 8'(got_q[0]);
				state_d           = S_D0;
			end
			S_D0: begin
				rv_d             = 1'b1;
				res_d.kind       = vqdcm_pkg::KIND_DESC;
				res_d.desc_index = 8'(got_q[0]);
				res_d.desc_addr  = haddr_q;
				res_d.desc_len   = vqdcm_pkg::HDR_LEN;
				res_d.desc_flags = vqdcm_pkg::DF_NEXT;
				res_d.desc_next  = 8'(got_q[1]);
				state_d          = S_D1;
			end
			S_D1: begin
				rv_d             = 1'b1;
				res_d.kind       = vqdcm_pkg::KIND_DESC;
				res_d.desc_index = 8'(got_q[1]);
				res_d.desc_addr  = cmd_q.data_addr;
				res_d.desc_len   = vqdcm_pkg::BLK_BASE_LEN << bsl_q;
				res_d.desc_flags = data_flags;
				res_d.desc_next  = 8'(got_q[2]);
				state_d          = S_D2;
			end
			S_D2: begin
				rv_d             = 1'b1;
				res_d.kind       = vqdcm_pkg::KIND_DESC;
				res_d.desc_index = 8'(got_q[2]);
				res_d.desc_addr  = saddr_q;
				res_d.desc_len   = vqdcm_pkg::STS_LEN;
				res_d.desc_flags = vqdcm_pkg::DF_WRITE;
				state_d          = S_POST;
			end
			S_POST: begin
				rv_d             = 1'b1;
				res_d.kind       = vqdcm_pkg::KIND_POST;
				res_d.desc_index = 8'(got_q[0]);
				res_d.avail_idx  = avail_q;
				res_d.last       = 1'b1;
				state_d          = S_IDLE;
			end
			S_CHK: begin
				rv_d = 1'b1;
				if (!in_range) begin
					res_d.kind       = vqdcm_pkg::KIND_ERR;
					res_d.error_code = vqdcm_pkg::ERR_RANGE;
					res_d.last       = 1'b1;
					state_d          = S_IDLE;
				end else if (free_q[cur_idx]) begin
					res_d.kind       = vqdcm_pkg::KIND_ERR;
					res_d.desc_index = 8'(cur_idx);
					res_d.error_code = vqdcm_pkg::ERR_DFREE;
					res_d.last       = 1'b1;
					state_d          = S_IDLE;
				end else begin
					// zeroing write; chain entry arrives from RAM next cycle
					res_d.kind       = vqdcm_pkg::KIND_DESC;
					res_d.desc_index = 8'(cur_idx);
					state_d          = S_NEXT;
				end
			end
			S_NEXT: begin
				if (walk_more) begin
					state_d = S_CHK;
				end else begin
					rv_d       = 1'b1;
					res_d.kind = vqdcm_pkg::KIND_DONE;
					res_d.last = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer state, allocation state and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_q      <= '1;
			avail_q     <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			cmd_q       <= '0;
			scan_q      <= '0;
			found_q     <= '0;
			got_q[0]    <= '0;
			got_q[1]    <= '0;
			got_q[2]    <= '0;
			haddr_q     <= '0;
			saddr_q     <= '0;
			cur_q       <= '0;
			step_q      <= '0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= rv_d;
			res_q       <= res_d;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						scan_q  <= '0;
						found_q <= '0;
						cur_q   <= cmd.head_id;
						step_q  <= '0;
					end
				end
				S_SCAN: begin
					if (scan_free) begin
						got_q[found_q] <= scan_q;
						found_q        <= 2'(found_q + 2'd1);
					end
					scan_q <= IDX_W'(scan_q + 1'b1);
				end
				S_HADDR: begin
					haddr_q <= alu_rsp.sum;
					free_q  <= free_q & ~take_mask;
				end
				S_SADDR: begin
					saddr_q <= alu_rsp.sum;
				end
				S_POST: begin
					avail_q <= alu_rsp.sum[15:0];
				end
				S_CHK: begin
					if (in_range && !free_q[cur_idx]) begin
						free_q[cur_idx] <= 1'b1;
					end
				end
				S_NEXT: begin
					if (walk_more) begin
						cur_q  <= 16'(ram_rdata[IDX_W-1:0]);
						step_q <= 3'(step_q + 3'd1);
					end
				end
				default: ;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef SYNTHESIS
	// last result of an item leaves the block ready for the next one
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("busy after last result");

	// results only come from an accepted or running item
	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy) || $past(start))
		else $error("result without item");

	// descriptor writes only name real descriptors
	a_desc_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == vqdcm_pkg::KIND_DESC
		|-> 32'(result.desc_index) < 32'(QUEUE_SIZE))
		else $error("descriptor index out of range");

	// each avail post advances the counter by one
	a_avail_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == vqdcm_pkg::KIND_POST
		|-> avail_q == 16'($past(avail_q) + 16'd1))
		else $error("avail counter step");
`endif

endmodule
